@@ rtl/core/gbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

    localparam logic [1:0] KIND_BOX   = 2'd0;
    localparam logic [1:0] KIND_SCORE = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    localparam logic [2:0] REG_BOX_COUNT   = 3'd0;
    localparam logic [2:0] REG_CLASS_COUNT = 3'd1;
    localparam logic [2:0] REG_REC_LIMIT   = 3'd2;
    localparam logic [2:0] REG_CLASS_LIMIT = 3'd3;
    localparam logic [2:0] REG_THRESHOLD   = 3'd4;
    localparam logic [2:0] REG_SCORE_FLOOR = 3'd5;

    localparam logic [8:0] BOX_CAP   = 9'd256;
    localparam logic [4:0] CLASS_CAP = 5'd16;
    localparam logic [6:0] REC_CAP   = 7'd64;

    typedef struct packed {
        logic load_box;
        logic load_score;
        logic run_start;
        logic class_init;
        logic class_next;
        logic sel_init;
        logic rd_cand;
        logic cap_cand;
        logic cand_next;
        logic p_init;
        logic rd_pick;
        logic rd_prev;
        logic p_next;
        logic best_upd;
        logic emit_pick;
        logic emit_pad;
        logic rec_clear;
        logic push_last;
    } t_cmd;

    typedef struct packed {
        logic class_ok;
        logic sel_ok;
        logic cand_ok;
        logic score_ok;
        logic p_ok;
        logic same_box;
        logic overlap;
        logic best_v;
        logic rec_ok;
        logic pad;
        logic pend_v;
        logic out_free;
        logic emit_ok;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/core/gbs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbs_ctrl import gbs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_kind,
    output logic            o_in_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLASS  = 4'd1;
    localparam logic [3:0] S_SEL    = 4'd2;
    localparam logic [3:0] S_CAND   = 4'd3;
    localparam logic [3:0] S_SCORE  = 4'd4;
    localparam logic [3:0] S_PCHK   = 4'd5;
    localparam logic [3:0] S_PREAD  = 4'd6;
    localparam logic [3:0] S_OV0    = 4'd7;
    localparam logic [3:0] S_OV1    = 4'd8;
    localparam logic [3:0] S_OV2    = 4'd9;
    localparam logic [3:0] S_OV3    = 4'd10;
    localparam logic [3:0] S_PICK   = 4'd11;
    localparam logic [3:0] S_PADCHK = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load_box   = (i_kind == KIND_BOX);
                    o_cmd.load_score = (i_kind == KIND_SCORE);
                    if (i_kind == KIND_RUN) begin
                        o_cmd.run_start = 1'b1;
                        n_state         = S_CLASS;
                    end
                end
            end
            S_CLASS: begin
                if (i_sts.class_ok) begin
                    o_cmd.class_init = 1'b1;
                    n_state          = S_SEL;
                end else begin
                    n_state = S_PADCHK;
                end
            end
            S_SEL: begin
                if (i_sts.sel_ok) begin
                    o_cmd.sel_init = 1'b1;
                    n_state        = S_CAND;
                end else begin
                    o_cmd.class_next = 1'b1;
                    n_state          = S_CLASS;
                end
            end
            S_CAND: begin
                if (i_sts.cand_ok) begin
                    o_cmd.rd_cand = 1'b1;
                    n_state       = S_SCORE;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_SCORE: begin
                o_cmd.cap_cand = 1'b1;
                if (i_sts.score_ok) begin
                    o_cmd.p_init = 1'b1;
                    n_state      = S_PCHK;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CAND;
                end
            end
            S_PCHK: begin
                if (i_sts.p_ok) begin
                    o_cmd.rd_pick = 1'b1;
                    n_state       = S_PREAD;
                end else begin
                    o_cmd.best_upd  = 1'b1;
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CAND;
                end
            end
            S_PREAD: begin
                if (i_sts.same_box) begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CAND;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_OV0;
                end
            end
            S_OV0: n_state = S_OV1;
            S_OV1: n_state = S_OV2;
            S_OV2: n_state = S_OV3;
            S_OV3: begin
                if (i_sts.overlap) begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CAND;
                end else begin
                    o_cmd.p_next = 1'b1;
                    n_state      = S_PCHK;
                end
            end
            S_PICK: begin
                if (!i_sts.best_v) begin
                    o_cmd.class_next = 1'b1;
                    n_state          = S_CLASS;
                end else if (i_sts.emit_ok) begin
                    o_cmd.emit_pick = 1'b1;
                    n_state         = S_SEL;
                end
            end
            S_PADCHK: begin
                if (!i_sts.pad) begin
                    n_state = S_FIN;
                end else if (!i_sts.rec_ok) begin
                    o_cmd.rec_clear = 1'b1;
                    n_state         = S_FIN;
                end else if (i_sts.emit_ok) begin
                    o_cmd.emit_pad = 1'b1;
                end
            end
            S_FIN: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/gbs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbs_dp import gbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic [7:0]         i_box_index,
    input  wire logic [3:0]         i_score_class,
    input  wire logic signed [15:0] i_box_y1,
    input  wire logic signed [15:0] i_box_x1,
    input  wire logic signed [15:0] i_box_y2,
    input  wire logic signed [15:0] i_box_x2,
    input  wire logic signed [15:0] i_score,
    input  wire logic [7:0]         i_batch_number,
    input  wire logic               i_pad_after,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [8:0]       o_out_batch,
    output logic signed [4:0]       o_out_class,
    output logic signed [8:0]       o_out_box,
    output logic                    o_is_last
);

    // config
    logic [8:0]         r_box_count;
    logic [4:0]         r_class_count;
    logic [6:0]         r_rec_limit;
    logic [6:0]         r_class_limit;
    logic [15:0]        r_thr;
    logic signed [15:0] r_floor;

    // stores
    logic [63:0]        r_box_mem   [256];
    logic [15:0]        r_score_mem [4096];
    logic [7:0]         r_pick_mem  [64];
    logic [63:0]        r_box_q;
    logic signed [15:0] r_score_q;
    logic [7:0]         r_pick_q;

    // search state
    logic [4:0]         r_cls;
    logic [6:0]         r_sel;
    logic [8:0]         r_cand;
    logic [6:0]         r_p;
    logic [6:0]         r_rec;
    logic [7:0]         r_batch;
    logic               r_pad;
    logic [63:0]        r_cbox;
    logic signed [15:0] r_cscore;
    logic               r_best_v;
    logic [7:0]         r_best;
    logic signed [15:0] r_best_score;

    // overlap pipeline
    logic [15:0]        r_h, r_w, r_ca_h, r_ca_w, r_pb_h, r_pb_w;
    logic [31:0]        r_inter, r_aa, r_ab, r_inter3;
    logic [32:0]        r_uni;

    // record staging and output
    logic               r_pend_v;
    logic [8:0]         r_pend_batch;
    logic [4:0]         r_pend_class;
    logic [8:0]         r_pend_box;
    logic               r_out_v;
    logic [8:0]         r_out_batch;
    logic [4:0]         r_out_class;
    logic [8:0]         r_out_box;
    logic               r_out_last;

    logic [8:0]         w_nb;
    logic [4:0]         w_nc;
    logic [6:0]         w_lim;
    logic               w_rec_ok;
    logic               w_out_free;
    logic [63:0]        w_box_norm;
    logic signed [15:0] w_cy1, w_cx1, w_cy2, w_cx2, w_py1, w_px1, w_py2, w_px2;
    logic signed [15:0] w_iy1, w_ix1, w_iy2, w_ix2;
    logic signed [16:0] w_h17, w_w17, w_cah17, w_caw17, w_pbh17, w_pbw17;
    logic [48:0]        w_rhs;
    logic [48:0]        w_lhs;
    logic               w_emit;

    assign w_nb  = (r_box_count > BOX_CAP) ? BOX_CAP : r_box_count;
    assign w_nc  = (r_class_count > CLASS_CAP) ? CLASS_CAP : r_class_count;
    assign w_lim = (r_rec_limit > REC_CAP) ? REC_CAP : r_rec_limit;
    assign w_rec_ok   = r_rec < w_lim;
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_emit     = i_cmd.emit_pick || i_cmd.emit_pad;

    // corners sorted on load: {ymin, xmin, ymax, xmax}
    assign w_box_norm = {(i_box_y1 < i_box_y2) ? i_box_y1 : i_box_y2,
                         (i_box_x1 < i_box_x2) ? i_box_x1 : i_box_x2,
                         (i_box_y1 < i_box_y2) ? i_box_y2 : i_box_y1,
                         (i_box_x1 < i_box_x2) ? i_box_x2 : i_box_x1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count   <= '0;
            r_class_count <= '0;
            r_rec_limit   <= '0;
            r_class_limit <= '0;
            r_thr         <= '0;
            r_floor       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOX_COUNT:   r_box_count   <= i_cfg_data[8:0];
                REG_CLASS_COUNT: r_class_count <= i_cfg_data[4:0];
                REG_REC_LIMIT:   r_rec_limit   <= i_cfg_data[6:0];
                REG_CLASS_LIMIT: r_class_limit <= i_cfg_data[6:0];
                REG_THRESHOLD:   r_thr         <= i_cfg_data;
                REG_SCORE_FLOOR: r_floor       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_box) begin
            r_box_mem[i_box_index] <= w_box_norm;
        end
        if (i_cmd.rd_cand) begin
            r_box_q <= r_box_mem[r_cand[7:0]];
        end else if (i_cmd.rd_prev) begin
            r_box_q <= r_box_mem[r_pick_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_score) begin
            r_score_mem[{i_score_class, i_box_index}] <= i_score;
        end
        if (i_cmd.rd_cand) begin
            r_score_q <= r_score_mem[{r_cls[3:0], r_cand[7:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pick) begin
            r_pick_mem[r_sel[5:0]] <= r_best;
        end
        if (i_cmd.rd_pick) begin
            r_pick_q <= r_pick_mem[r_p[5:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec    <= '0;
            r_best_v <= 1'b0;
            r_pad    <= 1'b0;
        end else begin
            if (i_cmd.rec_clear) begin
                r_rec <= '0;
            end else if (w_emit) begin
                r_rec <= r_rec + 7'd1;
            end
            if (i_cmd.sel_init) begin
                r_best_v <= 1'b0;
            end else if (i_cmd.best_upd && (!r_best_v || r_cscore > r_best_score)) begin
                r_best_v <= 1'b1;
            end
            if (i_cmd.run_start) begin
                r_pad <= i_pad_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_batch <= i_batch_number;
            r_cls   <= '0;
        end else if (i_cmd.class_next) begin
            r_cls <= r_cls + 5'd1;
        end
        if (i_cmd.class_init) begin
            r_sel <= '0;
        end else if (i_cmd.emit_pick) begin
            r_sel <= r_sel + 7'd1;
        end
        if (i_cmd.sel_init) begin
            r_cand <= '0;
        end else if (i_cmd.cand_next) begin
            r_cand <= r_cand + 9'd1;
        end
        if (i_cmd.p_init) begin
            r_p <= '0;
        end else if (i_cmd.p_next) begin
            r_p <= r_p + 7'd1;
        end
        if (i_cmd.cap_cand) begin
            r_cbox   <= r_box_q;
            r_cscore <= r_score_q;
        end
        if (i_cmd.best_upd && (!r_best_v || r_cscore > r_best_score)) begin
            r_best       <= r_cand[7:0];
            r_best_score <= r_cscore;
        end
    end

    // overlap: three register stages from the fetched box
    assign w_cy1 = r_cbox[63:48];
    assign w_cx1 = r_cbox[47:32];
    assign w_cy2 = r_cbox[31:16];
    assign w_cx2 = r_cbox[15:0];
    assign w_py1 = r_box_q[63:48];
    assign w_px1 = r_box_q[47:32];
    assign w_py2 = r_box_q[31:16];
    assign w_px2 = r_box_q[15:0];
    assign w_iy1 = (w_cy1 > w_py1) ? w_cy1 : w_py1;
    assign w_ix1 = (w_cx1 > w_px1) ? w_cx1 : w_px1;
    assign w_iy2 = (w_cy2 < w_py2) ? w_cy2 : w_py2;
    assign w_ix2 = (w_cx2 < w_px2) ? w_cx2 : w_px2;
    assign w_h17   = 17'(w_iy2) - 17'(w_iy1);
    assign w_w17   = 17'(w_ix2) - 17'(w_ix1);
    assign w_cah17 = 17'(w_cy2) - 17'(w_cy1);
    assign w_caw17 = 17'(w_cx2) - 17'(w_cx1);
    assign w_pbh17 = 17'(w_py2) - 17'(w_py1);
    assign w_pbw17 = 17'(w_px2) - 17'(w_px1);
    assign w_rhs = 49'(r_thr) * 49'(r_uni);
    assign w_lhs = {3'b000, r_inter3, 14'd0};

    always_ff @(posedge i_clk) begin
        r_h      <= w_h17[16] ? 16'd0 : w_h17[15:0];
        r_w      <= w_w17[16] ? 16'd0 : w_w17[15:0];
        r_ca_h   <= w_cah17[15:0];
        r_ca_w   <= w_caw17[15:0];
        r_pb_h   <= w_pbh17[15:0];
        r_pb_w   <= w_pbw17[15:0];
        r_inter  <= r_h * r_w;
        r_aa     <= r_ca_h * r_ca_w;
        r_ab     <= r_pb_h * r_pb_w;
        r_uni    <= {1'b0, r_aa} + {1'b0, r_ab} - {1'b0, r_inter};
        r_inter3 <= r_inter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.push_last) begin
                r_pend_v <= 1'b0;
            end
            if ((w_emit && r_pend_v) || i_cmd.push_last) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_emit && r_pend_v) || i_cmd.push_last) begin
            r_out_batch <= r_pend_batch;
            r_out_class <= r_pend_class;
            r_out_box   <= r_pend_box;
            r_out_last  <= i_cmd.push_last;
        end
        if (i_cmd.emit_pick) begin
            r_pend_batch <= {1'b0, r_batch};
            r_pend_class <= {1'b0, r_cls[3:0]};
            r_pend_box   <= {1'b0, r_best};
        end else if (i_cmd.emit_pad) begin
            r_pend_batch <= '1;
            r_pend_class <= '1;
            r_pend_box   <= '1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_batch = r_out_batch;
    assign o_out_class = r_out_class;
    assign o_out_box   = r_out_box;
    assign o_is_last   = r_out_last;

    assign o_sts.class_ok = (r_cls < w_nc) && w_rec_ok;
    assign o_sts.sel_ok   = (r_sel < r_class_limit) && (r_sel < REC_CAP) && w_rec_ok;
    assign o_sts.cand_ok  = r_cand < w_nb;
    assign o_sts.score_ok = r_score_q >= r_floor;
    assign o_sts.p_ok     = r_p < r_sel;
    assign o_sts.same_box = r_pick_q == r_cand[7:0];
    assign o_sts.overlap  = w_lhs > w_rhs;
    assign o_sts.best_v   = r_best_v;
    assign o_sts.rec_ok   = w_rec_ok;
    assign o_sts.pad      = r_pad;
    assign o_sts.pend_v   = r_pend_v;
    assign o_sts.out_free = w_out_free;
    assign o_sts.emit_ok  = !r_pend_v || w_out_free;

endmodule
`default_nettype wire

@@ rtl/core/greedy_box_suppression_core.sv @@
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      kind, indexes, box, score, batch, pad
// out       output     o_out_valid / i_out_ready    batch, class, box, is_last
// cfg       input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// Box and score loads are accepted back to back.
// A run request holds o_in_ready low for the whole search: each candidate is read and
// scored, and one at or above the floor is tested against the earlier picks of the
// class one pick at a time (one box memory read port, a 3-stage overlap pipeline).
// Reset is synchronous, active low; the stores are not cleared.
// A stalled output stalls the search only when a second record is ready.
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_suppression_core import gbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic [7:0]         i_box_index,
    input  wire logic [3:0]         i_score_class,
    input  wire logic signed [15:0] i_box_y1,
    input  wire logic signed [15:0] i_box_x1,
    input  wire logic signed [15:0] i_box_y2,
    input  wire logic signed [15:0] i_box_x2,
    input  wire logic signed [15:0] i_score,
    input  wire logic [7:0]         i_batch_number,
    input  wire logic               i_pad_after,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [8:0]       o_out_batch,
    output logic signed [4:0]       o_out_class,
    output logic signed [8:0]       o_out_box,
    output logic                    o_is_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    gbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gbs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_box_index    (i_box_index),
        .i_score_class  (i_score_class),
        .i_box_y1       (i_box_y1),
        .i_box_x1       (i_box_x1),
        .i_box_y2       (i_box_y2),
        .i_box_x2       (i_box_x2),
        .i_score        (i_score),
        .i_batch_number (i_batch_number),
        .i_pad_after    (i_pad_after),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_batch    (o_out_batch),
        .o_out_class    (o_out_class),
        .o_out_box      (o_out_box),
        .o_is_last      (o_is_last)
    );

endmodule
`default_nettype wire

@@ rtl/core/gbs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbs_checker import gbs_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [1:0]         i_kind,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [8:0]  o_out_box,
    input wire logic               o_is_last
);

    // a run request blocks further requests right away
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_RUN) |=> !o_in_ready)
        else $error("run request did not block input");

    // loads never stall input
    a_load_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind != KIND_RUN) |=> o_in_ready)
        else $error("load request stalled input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_box)
            && $stable(o_is_last)))
        else $error("stalled record changed");

    // once a run's last record is on the port, input is open again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last && !$stable(o_is_last)) |-> o_in_ready)
        else $error("last record shown while run still busy");

endmodule

bind greedy_box_suppression_core gbs_checker u_gbs_checker (.*);
`default_nettype wire
